// File: hdl/i2cra_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - shared definitions
// Field widths, opcodes, register indexes and bus phase codes.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 2'd1;

  localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd50;
  localparam logic [BYTE_W-1:0]     ACK_TIMEOUT_RST    = 8'd250;

  // Bus sequencer phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE      = 15'h0001,
    PH_START     = 15'h0002,
    PH_SEND_AW   = 15'h0004,
    PH_ACK_AW    = 15'h0008,
    PH_SEND_REG  = 15'h0010,
    PH_ACK_REG   = 15'h0020,
    PH_SEND_DATA = 15'h0040,
    PH_ACK_DATA  = 15'h0080,
    PH_RESTART   = 15'h0100,
    PH_SEND_AR   = 15'h0200,
    PH_ACK_AR    = 15'h0400,
    PH_READ      = 15'h0800,
    PH_NACK      = 15'h1000,
    PH_STOP_OK   = 15'h2000,
    PH_STOP_ERR  = 15'h4000
  } phase_t;

endpackage

// File: hdl/i2cra_if.sv
// ----------------------------------------------------------------------------
// I2C register access master - channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cra_req_if;
  import i2cra_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   reg_address;
  logic [BYTE_W-1:0]   write_data;
  logic                sda_sample;

  modport source (output valid, opcode, reg_address, write_data, sda_sample, input ready);
  modport sink   (input valid, opcode, reg_address, write_data, sda_sample, output ready);
endinterface

interface i2cra_res_if;
  import i2cra_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_enable;
  logic              busy_res;
  logic              done_res;
  logic              no_ack_error;
  logic [BYTE_W-1:0] read_byte;
  logic              rejected;

  modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  no_ack_error, read_byte, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  no_ack_error, read_byte, rejected, output ready);
endinterface

interface i2cra_cfg_if;
  import i2cra_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/i2c_register_access_master.sv
// Each accepted word waits in the input register; its result word is then registered in the result register.
// Throughput: one word per cycle while results are taken; the step is one registered pass
// through the bus sequencer, and a held word waits while an untaken result is pending.
// Reset: synchronous, active high; sequencer idle, SCL and SDA high and
// driven, device address 50, acknowledge timeout 250.
// ----------------------------------------------------------------------------
// I2C register access master
// Bit-level master for single register writes and reads; one tick word is
// one step of the bus sequencer.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic clk,
  input  logic rst,
  i2cra_req_if.sink   req,
  i2cra_res_if.source res,
  i2cra_cfg_if.sink   cfg
);
  import i2cra_pkg::*;

  // Configuration registers
  logic [DEV_ADDR_W-1:0] device_address;
  logic [BYTE_W-1:0]     ack_timeout;

  // Input stage
  logic                in_valid;
  logic [OPCODE_W-1:0] in_opcode;
  logic [BYTE_W-1:0]   in_reg_address;
  logic [BYTE_W-1:0]   in_write_data;
  logic                in_sda;
  logic                advance;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [1:0]        sub_tick, sub_tick_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [BYTE_W-1:0] poll_count, poll_count_next;
  logic              is_read, is_read_next;
  logic [BYTE_W-1:0] held_register, held_register_next;
  logic [BYTE_W-1:0] held_data, held_data_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              sda_en, sda_en_next;

  // Result flags of this step
  logic              done_next;
  logic              err_next;
  logic              rej_next;
  logic [BYTE_W-1:0] rbyte_next;

  logic [BYTE_W-1:0] addr_wr_byte;
  logic [BYTE_W-1:0] addr_rd_byte;

  assign addr_wr_byte = {device_address, 1'b0};
  assign addr_rd_byte = {device_address, 1'b1};

  // Move the input stage on when the result register is free or being emptied
  assign advance   = in_valid && (!res.valid || res.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      ack_timeout    <= ACK_TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEVICE_ADDRESS: device_address <= cfg.data[DEV_ADDR_W-1:0];
        REG_ACK_TIMEOUT:    ack_timeout    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register: hold the word until the sequencer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_opcode      <= req.opcode;
      in_reg_address <= req.reg_address;
      in_write_data  <= req.write_data;
      in_sda         <= req.sda_sample;
    end
  end

  // One step of the bus sequencer
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    sub_tick_next      = sub_tick;
    shift_byte_next    = shift_byte;
    poll_count_next    = poll_count;
    is_read_next       = is_read;
    held_register_next = held_register;
    held_data_next     = held_data;
    scl_next           = scl;
    sda_next           = sda;
    sda_en_next        = sda_en;
    done_next          = 1'b0;
    err_next           = 1'b0;
    rej_next           = 1'b0;
    rbyte_next         = '0;

    if (in_opcode == OP_WRITE || in_opcode == OP_READ) begin
      if (phase != PH_IDLE) begin
        // Busy: drop the request
        rej_next = 1'b1;
      end else begin
        held_register_next = in_reg_address;
        held_data_next     = in_write_data;
        is_read_next       = (in_opcode == OP_READ);
        shift_byte_next    = '0;
        phase_next         = PH_START;
        sub_tick_next      = '0;
        bit_count_next     = '0;
        poll_count_next    = '0;
      end
    end else if (in_opcode == OP_TICK && phase != PH_IDLE) begin
      case (phase)
        PH_START, PH_RESTART: begin
          if (sub_tick == 2'd0) begin
            {scl_next, sda_next, sda_en_next} = 3'b111;
            sub_tick_next = 2'd1;
          end else begin
            // Start condition: SDA falls with SCL high
            {scl_next, sda_next, sda_en_next} = 3'b101;
            phase_next      = (phase == PH_START) ? PH_SEND_AW : PH_SEND_AR;
            shift_byte_next = (phase == PH_START) ? addr_wr_byte : addr_rd_byte;
            sub_tick_next   = '0;
            bit_count_next  = '0;
            poll_count_next = '0;
          end
        end

        PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: begin
          scl_next    = (sub_tick == 2'd1);
          sda_next    = shift_byte[BYTE_W-1];
          sda_en_next = 1'b1;
          if (sub_tick < 2'd2) begin
            sub_tick_next = sub_tick + 2'd1;
          end else begin
            sub_tick_next   = '0;
            shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
            bit_count_next  = bit_count + 4'd1;
            if (bit_count >= 4'd7) begin
              case (phase)
                PH_SEND_AW:   phase_next = PH_ACK_AW;
                PH_SEND_REG:  phase_next = PH_ACK_REG;
                PH_SEND_DATA: phase_next = PH_ACK_DATA;
                default:      phase_next = PH_ACK_AR;
              endcase
              bit_count_next  = '0;
              poll_count_next = '0;
            end
          end
        end

        PH_ACK_AW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_AR: begin
          scl_next    = (sub_tick != 2'd0);
          sda_next    = 1'b1;
          sda_en_next = 1'b0;
          if (sub_tick < 2'd2) begin
            sub_tick_next = sub_tick + 2'd1;
          end else if (!in_sda) begin
            // Acknowledged: advance to the next part of the transaction
            sub_tick_next   = '0;
            bit_count_next  = '0;
            poll_count_next = '0;
            case (phase)
              PH_ACK_AW: begin
                phase_next      = PH_SEND_REG;
                shift_byte_next = held_register;
              end
              PH_ACK_REG: begin
                if (is_read) begin
                  phase_next = PH_RESTART;
                end else begin
                  phase_next      = PH_SEND_DATA;
                  shift_byte_next = held_data;
                end
              end
              PH_ACK_DATA: phase_next = PH_STOP_OK;
              default: begin
                phase_next      = PH_READ;
                shift_byte_next = '0;
              end
            endcase
          end else if (poll_count >= ack_timeout) begin
            phase_next      = PH_STOP_ERR;
            sub_tick_next   = '0;
            bit_count_next  = '0;
            poll_count_next = '0;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end

        PH_READ: begin
          sda_next    = 1'b1;
          sda_en_next = 1'b0;
          if (sub_tick == 2'd0) begin
            scl_next      = 1'b0;
            sub_tick_next = 2'd1;
          end else begin
            // Sample on the high half of SCL, MSB first
            scl_next        = 1'b1;
            shift_byte_next = {shift_byte[BYTE_W-2:0], in_sda};
            sub_tick_next   = '0;
            bit_count_next  = bit_count + 4'd1;
            if (bit_count >= 4'd7) begin
              phase_next     = PH_NACK;
              bit_count_next = '0;
            end
          end
        end

        PH_NACK: begin
          sda_next    = 1'b1;
          sda_en_next = 1'b1;
          if (sub_tick == 2'd0) begin
            scl_next      = 1'b0;
            sub_tick_next = 2'd1;
          end else begin
            scl_next      = 1'b1;
            phase_next    = PH_STOP_OK;
            sub_tick_next = '0;
          end
        end

        PH_STOP_OK, PH_STOP_ERR: begin
          sda_en_next = 1'b1;
          if (sub_tick == 2'd0) begin
            {scl_next, sda_next} = 2'b00;
            sub_tick_next = 2'd1;
          end else if (sub_tick == 2'd1) begin
            {scl_next, sda_next} = 2'b10;
            sub_tick_next = 2'd2;
          end else begin
            // Stop condition: SDA rises with SCL high; transaction ends
            {scl_next, sda_next} = 2'b11;
            done_next       = 1'b1;
            err_next        = (phase == PH_STOP_ERR);
            rbyte_next      = (phase == PH_STOP_OK && is_read) ? shift_byte : '0;
            phase_next      = PH_IDLE;
            sub_tick_next   = '0;
            bit_count_next  = '0;
            poll_count_next = '0;
          end
        end

        default: begin
          phase_next      = PH_IDLE;
          sub_tick_next   = '0;
          bit_count_next  = '0;
          poll_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      sub_tick      <= '0;
      shift_byte    <= '0;
      poll_count    <= '0;
      is_read       <= 1'b0;
      held_register <= '0;
      held_data     <= '0;
      scl           <= 1'b1;
      sda           <= 1'b1;
      sda_en        <= 1'b1;
    end else if (advance) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      sub_tick      <= sub_tick_next;
      shift_byte    <= shift_byte_next;
      poll_count    <= poll_count_next;
      is_read       <= is_read_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      scl           <= scl_next;
      sda           <= sda_next;
      sda_en        <= sda_en_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.scl_level    <= scl_next;
      res.sda_level    <= sda_next;
      res.sda_enable   <= sda_en_next;
      res.busy_res     <= (phase_next != PH_IDLE);
      res.done_res     <= done_next;
      res.no_ack_error <= done_next && err_next;
      res.read_byte    <= rbyte_next;
      res.rejected     <= rej_next;
    end
  end

endmodule
